>>> src/esd_pkg.sv
// Shared widths, signature codes and types for the engine signature detector.
// No dependencies; every other file imports this package.
`default_nettype none
package esd_pkg;

   localparam int WORD_W   = 32;
   localparam int LEN_W    = 26;
   localparam int OFS_W    = 25;
   localparam int COUNT_W  = 24;
   localparam int WIN_DEPTH = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] WIN_FILL  = COUNT_W'(WIN_DEPTH - 1);

   // Marker opcodes at the candidate offset
   localparam logic [WORD_W-1:0] MARK_A = 32'h4700_bc01;
   localparam logic [WORD_W-1:0] MARK_B = 32'h0000_4700;
   // Opcodes allowed in the word before the marker
   localparam logic [WORD_W-1:0] PREV_A = 32'hbc70_d1f1;
   localparam logic [WORD_W-1:0] PREV_B = 32'hbc01_bcf0;
   localparam logic [WORD_W-1:0] PREV_C = 32'hbc70_ddf0;
   // I/O register addresses twelve bytes after the marker
   localparam logic [WORD_W-1:0] IO_A = 32'h0400_0100;
   localparam logic [WORD_W-1:0] IO_B = 32'h0400_0200;
   localparam logic [WORD_W-1:0] IO_C = 32'h0400_00e0;

   localparam logic [3:0] POLY_MAX = 4'd12;
   localparam logic [3:0] RATE_MIN = 4'd1;
   localparam logic [3:0] RATE_MAX = 4'd12;
   localparam logic [3:0] DACN_MIN = 4'd8;
   localparam logic [3:0] DACN_MAX = 4'd11;

   // Window slots, newest first
   localparam int SLOT_LEVELS = 0;
   localparam int SLOT_PARAM  = 1;
   localparam int SLOT_IO     = 4;
   localparam int SLOT_MARK   = 7;
   localparam int SLOT_PREV   = 8;

   typedef logic [WIN_DEPTH-1:0][WORD_W-1:0] esd_window_type;

   typedef struct packed {
      esd_window_type     window;
      logic [COUNT_W-1:0] count;
      logic               done;
   } esd_scan_type;

   typedef struct packed {
      logic             hit;
      logic [OFS_W-1:0] offset;
   } esd_match_type;

endpackage
`default_nettype wire

>>> src/esd_window.sv
// Scan state: nine-word history window, saturating word count and done flag.
// Depends on esd_pkg.
`default_nettype none
module esd_window
   import esd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [WORD_W-1:0] word,
   input  wire logic              last,
   input  wire logic              hit,
   output esd_scan_type           scan
);

   esd_window_type     window_ff, window_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               done_ff, done_in;

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      if (step) begin
         if (last) begin
            // end of image: back to the empty scan
            window_in = '0;
            count_in  = '0;
            done_in   = 1'b0;
         end else begin
            window_in = {window_ff[WIN_DEPTH-2:0], word};
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            done_in = done_ff | hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
         done_ff   <= 1'b0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
      end
   end

   assign scan.window = window_ff;
   assign scan.count  = count_ff;
   assign scan.done   = done_ff;

endmodule
`default_nettype wire

>>> src/esd_match.sv
// Signature compare for the candidate offset against the current word.
// Depends on esd_pkg; purely combinational.
`default_nettype none
module esd_match
   import esd_pkg::*;
(
   input  wire esd_scan_type      scan,
   input  wire logic [WORD_W-1:0] word,
   input  wire logic [LEN_W-1:0]  rom_length,
   output esd_match_type          result
);

   logic [WORD_W-1:0]  mark, prev, io, par, levels;
   logic [3:0]         poly, vol, rate, dacn;
   logic [COUNT_W-1:0] cand;
   logic [LEN_W-1:0]   ofs;
   logic [LEN_W:0]     ofs_end;
   logic [11:0]        lev12;
   logic [LEN_W:0]     tbl;
   logic               codes_ok, par_ok, len_ok;

   always_comb begin
      mark   = scan.window[SLOT_MARK];
      prev   = scan.window[SLOT_PREV];
      io     = scan.window[SLOT_IO];
      par    = scan.window[SLOT_PARAM];
      levels = scan.window[SLOT_LEVELS];

      poly = par[11:8];
      vol  = par[15:12];
      rate = par[19:16];
      dacn = par[23:20];

      codes_ok = (mark == MARK_A || mark == MARK_B)
               && (prev == PREV_A || prev == PREV_B || prev == PREV_C)
               && (io == IO_A || io == IO_B || io == IO_C);
      par_ok = (vol != 4'd0) && (poly <= POLY_MAX)
             && (dacn >= DACN_MIN) && (dacn <= DACN_MAX)
             && (rate >= RATE_MIN) && (rate <= RATE_MAX)
             && (levels[WORD_W-1:8] == '0);

      // candidate offset is four bytes per word, eight words back
      cand    = scan.count - WIN_FILL;
      ofs     = {cand, 2'b00};
      ofs_end = {1'b0, ofs} + (LEN_W+1)'(36);
      // song table end: low address bits plus twelve times the level count
      lev12   = {1'b0, levels[7:0], 3'b000} + {2'b00, levels[7:0], 2'b00};
      tbl     = {1'b0, word[LEN_W-1:0]} + (LEN_W+1)'(lev12);
      len_ok  = (ofs_end < {1'b0, rom_length}) && (tbl < {1'b0, rom_length});

      result.hit    = !scan.done && (scan.count >= WIN_FILL) && codes_ok && par_ok && len_ok;
      result.offset = ofs[OFS_W-1:0];
   end

endmodule
`default_nettype wire

>>> src/engine_signature_detector_top.sv
// Top level of the engine signature detector: input register, scan state,
// signature compare and result register. Depends on esd_pkg, esd_window, esd_match.
//
// Usage:
//  - req_ channel: one aligned 32-bit little-endian image word per item,
//    starting at byte 0, with req_last_word set on the final word.
//  - rsp_ channel: at most one item per image. rsp_found = 1 with the byte
//    offset of the marker word at the first match; rsp_found = 0 with offset
//    zero when the final word passes without a match. Nothing after a match.
//  - csr_ channel: writes rom_length (bytes). csr_ready is always high;
//    write it only while no word is in flight.
// Path: the word that causes a result passes the input register, then the
// result register. The compare is fixed logic on the window.
// Throughput: one word per cycle while rsp_stall holds no waiting result.
// Stall: while rsp_stall holds a waiting result, the word in the input
// register waits too and req_stall rises; a register stage on each side
// keeps both moving when rsp_stall is low.
// Reset: synchronous, clears rom_length, the window, the word count, the
// done flag and both valid bits. After the final word the scan state returns
// to empty by itself, ready for the next image.
`default_nettype none
module engine_signature_detector_top
   import esd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // image words
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [WORD_W-1:0] req_rom_word,
   input  wire logic              req_last_word,
   // results
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_found,
   output      logic [OFS_W-1:0]  rsp_engine_offset,
   // rom_length register
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [LEN_W-1:0]  csr_wdata
);

   logic [LEN_W-1:0]  rom_length_ff, rom_length_in;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff, s1_word_in;
   logic              s1_last_ff, s1_last_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff, out_found_in;
   logic [OFS_W-1:0]  out_offset_ff, out_offset_in;

   logic              advance, s1_fire, emit;
   esd_scan_type      scan;
   esd_match_type     match;

   // advance whenever the result register is empty or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;

   esd_window u_window (
      .clock (clock),
      .reset (reset),
      .step  (s1_fire),
      .word  (s1_word_ff),
      .last  (s1_last_ff),
      .hit   (match.hit),
      .scan  (scan)
   );

   esd_match u_match (
      .scan       (scan),
      .word       (s1_word_ff),
      .rom_length (rom_length_ff),
      .result     (match)
   );

   // a match wins; otherwise the final word reports not-found unless done
   assign emit = s1_fire && (match.hit || (s1_last_ff && !scan.done));

   always_comb begin
      rom_length_in = rom_length_ff;
      if (csr_valid && csr_ready) begin
         rom_length_in = csr_wdata;
      end

      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_last_in  = s1_last_ff;
      if (!req_stall) begin
         // take a new word or drop the consumed one
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_word_in = req_rom_word;
            s1_last_in = req_last_word;
         end
      end

      out_valid_in  = out_valid_ff;
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      if (advance) begin
         out_valid_in = emit;
         if (emit) begin
            out_found_in  = match.hit;
            out_offset_in = match.hit ? match.offset : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_length_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         rom_length_ff <= rom_length_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload: hold unless loaded
   always_ff @(posedge clock) begin
      s1_word_ff    <= s1_word_in;
      s1_last_ff    <= s1_last_in;
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_engine_offset = out_offset_ff;

endmodule
`default_nettype wire

>>> src/esd_checker.sv
// Port-level checks for the engine signature detector, bound to its top level.
// Depends on esd_pkg and engine_signature_detector_top.
`default_nettype none
module esd_checker
   import esd_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic             rsp_found,
   input wire logic [OFS_W-1:0] rsp_engine_offset
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // not-found carries a zero offset
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_engine_offset == '0)
      else $error("not-found result with nonzero offset");

   // a marker offset is word aligned
   a_offset_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_engine_offset[1:0] == 2'b00)
      else $error("found offset not word aligned");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
                                 && $stable(rsp_engine_offset))
      else $error("stalled result changed");

   // the input side only stalls behind a stalled result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

endmodule

bind engine_signature_detector_top esd_checker u_esd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_found         (rsp_found),
   .rsp_engine_offset (rsp_engine_offset)
);
`default_nettype wire

>>> tb/esd_scan_checker.sv
`timescale 1ns / 100ps
// Checker for the engine signature detector: watches the word, result and
// length-register channels, predicts each image's result and compares it.
// Depends on esd_pkg.
module esd_scan_checker
   import esd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [WORD_W-1:0] req_rom_word,
   input  wire logic              req_last_word,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_found,
   input  wire logic [OFS_W-1:0]  rsp_engine_offset,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [LEN_W-1:0]  csr_wdata,
   output int                     fail_total,
   output int                     open_results,
   output int                     checked_results,
   output int                     found_results
);

   // predicted scan state
   logic [WORD_W-1:0]  history [WIN_DEPTH];
   logic [COUNT_W-1:0] words_seen;
   logic               reported;
   logic [LEN_W-1:0]   image_len;

   esd_match_type awaited_reports[$];
   int fails   = 0;
   int checked = 0;
   int hits    = 0;

   assign fail_total      = fails;
   assign open_results    = awaited_reports.size();
   assign checked_results = checked;
   assign found_results   = hits;

   task automatic note_failure(input string what);
      fails++;
      if (fails <= 10) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endtask

   task automatic restart_image();
      for (int k = 0; k < WIN_DEPTH; k++) begin
         history[k] = '0;
      end
      words_seen = '0;
      reported   = 1'b0;
   endtask

   // tail is the word 32 bytes past the candidate marker
   function automatic bit signature_at(input logic [WORD_W-1:0] tail);
      logic [WORD_W-1:0] par;
      logic [WORD_W-1:0] levels;
      logic [33:0]       table_end;
      par    = history[SLOT_PARAM];
      levels = history[SLOT_LEVELS];
      if (history[SLOT_MARK] != MARK_A && history[SLOT_MARK] != MARK_B) return 1'b0;
      if (history[SLOT_PREV] != PREV_A && history[SLOT_PREV] != PREV_B &&
          history[SLOT_PREV] != PREV_C) return 1'b0;
      if (history[SLOT_IO] != IO_A && history[SLOT_IO] != IO_B &&
          history[SLOT_IO] != IO_C) return 1'b0;
      if (par[11:8] > POLY_MAX || par[15:12] == 4'd0) return 1'b0;
      if (par[19:16] < RATE_MIN || par[19:16] > RATE_MAX) return 1'b0;
      if (par[23:20] < DACN_MIN || par[23:20] > DACN_MAX) return 1'b0;
      if (levels >= 32'd256) return 1'b0;
      table_end = 34'(tail[25:0]) + 34'(levels[7:0]) * 34'd12;
      return table_end < 34'(image_len);
   endfunction

   task automatic advance_scan(input logic [WORD_W-1:0] word, input logic last);
      logic [33:0]   cand;
      esd_match_type report;
      if (!reported && words_seen >= WIN_FILL) begin
         cand = 34'({words_seen - WIN_FILL, 2'b00});
         if (cand + 34'd36 < 34'(image_len) && signature_at(word)) begin
            reported      = 1'b1;
            report.hit    = 1'b1;
            report.offset = OFS_W'(cand);
            awaited_reports.push_back(report);
         end
      end
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
         history[k] = history[k-1];
      end
      history[0] = word;
      if (words_seen != COUNT_MAX) words_seen++;
      if (last) begin
         if (!reported) begin
            report.hit    = 1'b0;
            report.offset = '0;
            awaited_reports.push_back(report);
         end
         restart_image();
      end
   endtask

   always @(posedge clock) begin
      esd_match_type want;
      if (reset) begin
         restart_image();
         image_len = '0;
         awaited_reports.delete();
      end else begin
         if (csr_valid && csr_ready) image_len = csr_wdata;
         // compare before predicting: a result never comes from this edge's word
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (rsp_found === 1'b1) hits++;
            if (awaited_reports.size() == 0) begin
               note_failure($sformatf("unexpected result found=%0d offset=0x%0h",
                                      rsp_found, rsp_engine_offset));
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_found !== want.hit || rsp_engine_offset !== want.offset) begin
                  note_failure($sformatf("expected found=%0d offset=0x%0h, got found=%0d offset=0x%0h",
                                         want.hit, want.offset, rsp_found, rsp_engine_offset));
               end
            end
         end
         if (req_valid && !req_stall) advance_scan(req_rom_word, req_last_word);
      end
   end

endmodule

>>> tb/engine_signature_detector_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the engine signature detector: clock, reset, image and
// length-register stimulus, result-side stalls and the verdict.
// Depends on esd_pkg, engine_signature_detector_top and esd_scan_checker.
module engine_signature_detector_top_tb
   import esd_pkg::*;
;

   localparam int RANDOM_WORDS = 1100;
   localparam int HOLD_CYCLES  = 120;   // long receiver hold-off for back-pressure
   localparam int SETTLE       = 6;     // covers the input and result registers with margin
   localparam int DRAIN_LIMIT  = 4000;
   localparam logic [LEN_W-1:0] LEN_TOP = 26'h200_0000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [WORD_W-1:0] req_rom_word = '0;
   logic              req_last_word = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_found;
   logic [OFS_W-1:0]  rsp_engine_offset;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_wdata = '0;

   int fail_total;
   int open_results;
   int checked_results;
   int found_results;

   // stimulus bookkeeping
   logic [WORD_W-1:0] image_words[$];
   int  words_sent   = 0;
   int  images_sent  = 0;
   int  length_writes = 0;
   bit  hold_req = 1'b0;
   bit  hold_on  = 1'b0;

   always #4 clock = ~clock;

   engine_signature_detector_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rom_word      (req_rom_word),
      .req_last_word     (req_last_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_engine_offset (rsp_engine_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   esd_scan_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rom_word      (req_rom_word),
      .req_last_word     (req_last_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_engine_offset (rsp_engine_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .fail_total        (fail_total),
      .open_results      (open_results),
      .checked_results   (checked_results),
      .found_results     (found_results)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [WORD_W-1:0] pick_prev();
      case ($urandom_range(0, 2))
         0:       return PREV_A;
         1:       return PREV_B;
         default: return PREV_C;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_io();
      case ($urandom_range(0, 2))
         0:       return IO_A;
         1:       return IO_B;
         default: return IO_C;
      endcase
   endfunction

   // Background word: plain noise, opcodes from the signature sets, small numbers, all ones or all zeros.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? MARK_A : MARK_B;
         1:       return pick_prev();
         2:       return pick_io();
         3:       return $urandom_range(0, 300);
         4:       return $urandom_range(0, 1) ? '1 : '0;
         default: return $urandom;
      endcase
   endfunction

   // Engine parameter word; when bad, push one nibble outside its range.
   function automatic logic [WORD_W-1:0] make_param(input bit good);
      logic [3:0] poly, vol, rate, dacn;
      poly = 4'($urandom_range(0, 12));
      vol  = 4'($urandom_range(1, 15));
      rate = 4'($urandom_range(1, 12));
      dacn = 4'($urandom_range(8, 11));
      if (!good) begin
         case ($urandom_range(0, 3))
            0:       poly = 4'($urandom_range(13, 15));
            1:       vol  = 4'd0;
            2:       rate = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
            default: dacn = $urandom_range(0, 1) ? 4'($urandom_range(0, 7))
                                                   : 4'($urandom_range(12, 15));
         endcase
      end
      return {8'($urandom), dacn, rate, vol, poly, 8'($urandom)};
   endfunction

   // Build an image of n words; most carry a planted signature, some with
   // one part broken, so that scans get past the opcode compares.
   task automatic build_image(input int n, input logic [LEN_W-1:0] len);
      int          k;
      int          broken;
      int          levels;
      longint      room;
      longint      low;
      image_words.delete();
      for (int w = 0; w < n; w++) image_words.push_back(pick_word());
      if (n >= 9 && $urandom_range(0, 3) != 0) begin
         k      = $urandom_range(0, n - 9);
         broken = ($urandom_range(0, 4) < 2) ? $urandom_range(0, 5) : 6;
         if (k > 0) image_words[k-1] = (broken == 0) ? pick_word() : pick_prev();
         image_words[k]   = (broken == 1) ? pick_word() : ($urandom_range(0, 1) ? MARK_A : MARK_B);
         image_words[k+3] = (broken == 2) ? pick_word() : pick_io();
         image_words[k+6] = make_param(broken != 3);
         case ($urandom_range(0, 3))
            0:       levels = 0;
            1:       levels = 255;
            default: levels = $urandom_range(0, 255);
         endcase
         image_words[k+7] = (broken == 4) ? 32'(256 + $urandom_range(0, 3)) : 32'(levels);
         // hold the table end right at the image length: just inside or just past
         room = longint'(len) - 12 * levels;
         low  = (broken == 5) ? room + $urandom_range(0, 2) : room - 1 - $urandom_range(0, 2);
         image_words[k+8] = {6'($urandom), 26'(low)};
      end
   endtask

   // Offer the image word by word; hold each word until it is taken.
   task automatic send_image(input bit dense);
      int gap;
      for (int w = 0; w < image_words.size(); w++) begin
         gap = dense ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_rom_word  <= image_words[w];
         req_last_word <= (w == image_words.size() - 1);
         do @(posedge clock); while (req_stall);
         words_sent++;
      end
      images_sent++;
   endtask

   // Drop valid and wait until every expected result is in and the pipe is empty.
   task automatic wait_quiet();
      int spent;
      spent = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_results != 0 && spent < DRAIN_LIMIT) begin
         @(posedge clock);
         spent++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_wdata <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      length_writes++;
   endtask

   // Result-side stall: random bursts, plus one long hold-off on request.
   initial begin
      int span;
      int r;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            hold_on  = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 9) < 3);
            r = $urandom_range(0, 99);
            if (r < 80)      span = $urandom_range(1, 4);
            else if (r < 95) span = $urandom_range(5, 15);
            else             span = $urandom_range(20, 60);
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin
      int mode;
      int base_words;
      int n;
      int random_words;
      logic [LEN_W-1:0] len;
      random_words = 0;

      // hold reset, then release it at a rising edge
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: tightest legal nibbles with the table end one byte inside
      // the image and a match on the final word; widest legal nibbles with
      // 255 levels and words after the match; a lone final word with no match.
      write_length(26'd4096);
      image_words = '{PREV_A, MARK_A, 32'hFFFF_FFFF, 32'h0, IO_A, 32'h0, 32'h0,
                      32'h0081_1000, 32'd0, 32'hFC00_0FFF};
      send_image(1'b1);
      image_words = '{PREV_B, MARK_B, 32'h0, 32'hFFFF_FFFF, IO_B, 32'h0, 32'h0,
                      32'hFFBC_FCFF, 32'd255, 32'hFC00_040B, IO_C, 32'h0};
      send_image(1'b0);
      image_words = '{32'hFFFF_FFFF};
      send_image(1'b0);

      // Back-pressure: zero length, so every one-word image ends in not-found;
      // keep offering while the receiver holds off until the block stalls.
      write_length('0);
      hold_req = 1'b1;
      while (!hold_on) @(posedge clock);
      repeat (40) begin
         image_words = '{32'($urandom)};
         send_image(1'b1);
      end

      // Random phases: one length setting per phase, mostly near the image length,
      // with short and over-long streams mixed in.
      while (random_words < RANDOM_WORDS) begin
         mode       = $urandom_range(0, 9);
         base_words = $urandom_range(9, 48);
         if (mode == 0)      len = '0;
         else if (mode == 1) len = LEN_TOP;
         else                len = LEN_W'(4 * base_words + $urandom_range(0, 16) - 8);
         write_length(len);
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0:       n = $urandom_range(1, 8);
               1:       n = $urandom_range(80, 160);
               default: n = base_words + $urandom_range(0, 6) - 3;
            endcase
            build_image(n, len);
            send_image($urandom_range(0, 3) == 0);
            random_words += n;
         end
      end

      // drain, then give the verdict
      wait_quiet();
      $display("summary: %0d words in %0d images across %0d length settings",
               words_sent, images_sent, length_writes);
      $display("summary: %0d results checked, %0d with a signature found, %0d never arrived",
               checked_results, found_results, open_results);
      if (fail_total == 0 && open_results == 0) begin
         $display("engine_signature_detector_top_tb: done, clean");
      end else begin
         $display("engine_signature_detector_top_tb: done, errors");
      end
      $finish;
   end

   // Stop a hung run well past the slowest correct one.
   initial begin
      #3_200_000;
      $display("engine_signature_detector_top_tb: done, errors");
      $finish;
   end

endmodule
